// File: design/dald_pkg.sv
// Shared types and constants for the delta adjacency list decoder.
// No dependencies; imported by delta_adjacency_list_decoder_unit.
package dald_pkg;

    localparam int ID_W      = 32;
    localparam int NODE_BITS = ID_W;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 3;
    localparam int CFG_W     = 6;
    localparam int CFG_N     = 8;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int SKIP_W    = 64;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd8;

    localparam logic DIR_FWD      = 1'b0;
    localparam logic DIR_BACK     = 1'b1;
    localparam logic KIND_DEGREE  = 1'b0;
    localparam logic KIND_DELTA   = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FWD_DEG,
        PH_SKIP,
        PH_DEG,
        PH_FIRST,
        PH_DELTA
    } phase_t;

    typedef enum logic [1:0] {
        SQ_WAIT,
        SQ_BITS,
        SQ_MUL
    } seq_t;

endpackage

// File: design/delta_adjacency_list_decoder_unit.sv
// Delta adjacency list decoder: bit-serial field extraction over packed stream bytes.
// Depends on dald_pkg for types and constants.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------------
//   in       | sink      | in_valid/in_stall  | func, stream_byte, start_bit, group_base,
//            |           |                    | collapsed, backward
//   out      | source    | out_valid/out_stall| node_id, empty_list, last
//   config   | APB slave | psel/penable/pready| paddr, pwdata, prdata
//
// A byte is taken in SQ_WAIT; in_stall then holds off the next one while SQ_BITS consumes
// each stream bit it uses (up to 8) and, when the forward degree field ends, SQ_MUL
// computes the skip length. Bits go one per cycle through a single shift/accumulate unit,
// but a bit that completes a node result waits while the output register is full and stalled.
// rst_n clears all control state and loads every width register with 8.
module delta_adjacency_list_decoder_unit
    import dald_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [BYTE_W-1:0]   stream_byte,
    input  logic [POS_W-1:0]    start_bit,
    input  logic [ID_W-1:0]     group_base,
    input  logic                collapsed,
    input  logic                backward,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [ID_W-1:0]     node_id,
    output logic                empty_list,
    output logic                last,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int MAXF = MAX_FIELD_BITS;
    localparam int FW   = $clog2(MAXF + 2);
    localparam int PW   = MAXF + FW;
    localparam int SUMW = (PW + 1 > SKIP_W + 1) ? PW + 1 : SKIP_W + 1;

    logic [CFG_W-1:0]     cfg_reg [CFG_N];

    seq_t                 seq_reg, seq_next;
    phase_t               phase_reg, phase_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 more_reg, more_next;
    logic [MAXF:0]        accum_reg, accum_next;
    logic [FW-1:0]        bits_left_reg, bits_left_next;
    logic [MAXF-1:0]      entries_reg, entries_next;
    logic [SKIP_W-1:0]    skip_reg, skip_next;
    logic [NODE_BITS-1:0] cur_reg, cur_next;
    logic [NODE_BITS-1:0] base_reg, base_next;
    logic [1:0]           flags_reg, flags_next;

    logic                 out_valid_reg;
    logic [ID_W-1:0]      node_id_reg;
    logic                 empty_reg;
    logic                 last_reg;

    logic                 in_xfer;
    logic                 can_emit;
    logic                 step_go;
    logic                 fwd_done;
    logic                 field_end;
    logic                 emit_want;
    logic                 emit;
    logic [NODE_BITS-1:0] emit_node;
    logic                 emit_empty;
    logic                 emit_last;
    logic                 cur_bit;
    logic [MAXF:0]        acc_shift;
    logic [FW-1:0]        bl_dec;
    logic [FW-1:0]        delta_w;
    logic [FW-1:0]        fdw;
    logic [NODE_BITS-1:0] half;
    logic [NODE_BITS-1:0] node_val;
    logic [PW-1:0]        prod;
    logic [SUMW-1:0]      sum;
    logic                 cfg_wr;

    function automatic logic [FW-1:0] width_sel(input logic which, input logic col,
                                                input logic kind);
        logic [CFG_W-1:0] r;
        r = cfg_reg[{which, col, kind}];
        if (r == '0)
            return FW'(1);
        else if (r > CFG_W'(MAXF))
            return FW'(MAXF);
        else
            return FW'(r);
    endfunction

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = DATA_W'(cfg_reg[paddr[ADDR_W-1:2]]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_N; i++)
            begin
                cfg_reg[i] <= CFG_RESET;
            end
        end
        else if (cfg_wr)
        begin
            cfg_reg[paddr[ADDR_W-1:2]] <= pwdata[CFG_W-1:0];
        end
    end

    assign in_xfer  = in_valid && !in_stall;
    assign can_emit = !out_valid_reg || !out_stall;

    // sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SQ_WAIT:
            begin
                if (in_xfer && (func || phase_reg != PH_IDLE))
                    seq_next = SQ_BITS;
            end
            SQ_BITS:
            begin
                if (step_go)
                begin
                    priority if (fwd_done)
                        seq_next = SQ_MUL;
                    else if (phase_next == PH_IDLE || pos_reg == '0)
                        seq_next = SQ_WAIT;
                end
            end
            SQ_MUL:
            begin
                seq_next = more_reg ? SQ_BITS : SQ_WAIT;
            end
            default:
            begin
                seq_next = SQ_WAIT;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = (seq_reg != SQ_WAIT);
    end

    // shared bit unit and field decode
    always_comb
    begin
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        pos_next       = pos_reg;
        more_next      = more_reg;
        accum_next     = accum_reg;
        bits_left_next = bits_left_reg;
        entries_next   = entries_reg;
        skip_next      = skip_reg;
        cur_next       = cur_reg;
        base_next      = base_reg;
        flags_next     = flags_reg;

        emit       = 1'b0;
        emit_node  = '0;
        emit_empty = 1'b0;
        emit_last  = 1'b0;
        step_go    = 1'b0;
        fwd_done   = 1'b0;

        cur_bit   = byte_reg[pos_reg];
        acc_shift = {accum_reg[MAXF-1:0], cur_bit};
        bl_dec    = bits_left_reg - FW'(1);
        delta_w   = width_sel(flags_reg[1], flags_reg[0], KIND_DELTA);
        fdw       = width_sel(DIR_FWD, flags_reg[0], KIND_DELTA);
        half      = NODE_BITS'(acc_shift[MAXF:1]);
        node_val  = acc_shift[0] ? (base_reg - half) : (base_reg + half);
        prod      = PW'(accum_reg[MAXF-1:0] - MAXF'(1)) * PW'(fdw);
        sum       = SUMW'(prod) + SUMW'(fdw) + SUMW'(1);

        field_end = (phase_reg != PH_SKIP) && (bl_dec == '0);
        emit_want = field_end && (phase_reg == PH_FIRST || phase_reg == PH_DELTA ||
                                  (phase_reg == PH_DEG && acc_shift == '0));

        unique case (seq_reg)
            SQ_WAIT:
            begin
                if (in_xfer)
                begin
                    byte_next = stream_byte;
                    if (func)
                    begin
                        base_next      = NODE_BITS'(group_base);
                        flags_next     = {backward, collapsed};
                        cur_next       = '0;
                        entries_next   = '0;
                        skip_next      = '0;
                        accum_next     = '0;
                        bits_left_next = width_sel(DIR_FWD, collapsed, KIND_DEGREE);
                        phase_next     = backward ? PH_FWD_DEG : PH_DEG;
                        pos_next       = ~start_bit;
                    end
                    else
                    begin
                        pos_next = '1;
                    end
                end
            end
            SQ_BITS:
            begin
                step_go = !emit_want || can_emit;
                if (step_go)
                begin
                    pos_next  = pos_reg - POS_W'(1);
                    more_next = (pos_reg != '0);
                    if (phase_reg == PH_SKIP)
                    begin
                        skip_next = skip_reg - SKIP_W'(1);
                        if (skip_reg == SKIP_W'(1))
                        begin
                            phase_next     = PH_DEG;
                            accum_next     = '0;
                            bits_left_next = width_sel(DIR_BACK, flags_reg[0], KIND_DEGREE);
                        end
                    end
                    else
                    begin
                        accum_next     = acc_shift;
                        bits_left_next = bl_dec;
                        if (field_end)
                        begin
                            unique case (phase_reg)
                                PH_FWD_DEG:
                                begin
                                    fwd_done = 1'b1;
                                end
                                PH_DEG:
                                begin
                                    if (acc_shift == '0)
                                    begin
                                        emit       = 1'b1;
                                        emit_empty = 1'b1;
                                        emit_last  = 1'b1;
                                        phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        entries_next   = acc_shift[MAXF-1:0];
                                        phase_next     = PH_FIRST;
                                        accum_next     = '0;
                                        bits_left_next = delta_w + FW'(1);
                                    end
                                end
                                PH_FIRST, PH_DELTA:
                                begin
                                    if (phase_reg == PH_FIRST)
                                        cur_next = node_val;
                                    else
                                        cur_next = cur_reg + NODE_BITS'(acc_shift);
                                    entries_next = entries_reg - MAXF'(1);
                                    emit         = 1'b1;
                                    emit_node    = cur_next;
                                    emit_last    = (entries_reg == MAXF'(1));
                                    if (entries_reg == MAXF'(1))
                                    begin
                                        phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        phase_next     = PH_DELTA;
                                        accum_next     = '0;
                                        bits_left_next = delta_w;
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
            end
            SQ_MUL:
            begin
                if (accum_reg[MAXF-1:0] == '0)
                begin
                    phase_next     = PH_DEG;
                    accum_next     = '0;
                    bits_left_next = width_sel(DIR_BACK, flags_reg[0], KIND_DEGREE);
                end
                else
                begin
                    phase_next = PH_SKIP;
                    skip_next  = (|sum[SUMW-1:SKIP_W]) ? '1 : sum[SKIP_W-1:0];
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_WAIT;
            phase_reg     <= PH_IDLE;
            byte_reg      <= '0;
            pos_reg       <= '0;
            more_reg      <= 1'b0;
            accum_reg     <= '0;
            bits_left_reg <= '0;
            entries_reg   <= '0;
            skip_reg      <= '0;
            cur_reg       <= '0;
            base_reg      <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            byte_reg      <= byte_next;
            pos_reg       <= pos_next;
            more_reg      <= more_next;
            accum_reg     <= accum_next;
            bits_left_reg <= bits_left_next;
            entries_reg   <= entries_next;
            skip_reg      <= skip_next;
            cur_reg       <= cur_next;
            base_reg      <= base_next;
            flags_reg     <= flags_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            node_id_reg <= ID_W'(emit_node);
            empty_reg   <= emit_empty;
            last_reg    <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign node_id    = node_id_reg;
    assign empty_list = empty_reg;
    assign last       = last_reg;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for delta_adjacency_list_decoder_unit: packs adjacency records into
// bytes, predicts each neighbor transfer with an internal bit-serial decoder and checks it.
// Depends on dald_pkg and the decoder RTL only.
module tb_top;
    import dald_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_FIELD     = 32;
    localparam int REG_STRIDE    = 4;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int SKIP_LIMIT    = 256;
    localparam int RUN_LIMIT     = 5_000_000;
    localparam int FILL_RANDOM   = 0;
    localparam int FILL_ZERO     = 1;
    localparam int FILL_ONES     = 2;

    typedef struct packed {
        logic [ID_W-1:0] node_id;
        logic            empty_list;
        logic            is_last;
    } neighbor_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic                func        = 1'b0;
    logic [BYTE_W-1:0]   stream_byte = '0;
    logic [POS_W-1:0]    start_bit   = '0;
    logic [ID_W-1:0]     group_base  = '0;
    logic                collapsed   = 1'b0;
    logic                backward    = 1'b0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [ID_W-1:0]     node_id;
    logic                empty_list;
    logic                last;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // decoder state mirrored by the bench
    logic [CFG_W-1:0]    width_reg [CFG_N];
    phase_t              dec_phase    = PH_IDLE;
    logic [63:0]         field_bits   = '0;
    int unsigned         bits_left    = 0;
    logic [63:0]         entries_left = '0;
    logic [SKIP_W-1:0]   skip_left    = '0;
    logic [ID_W-1:0]     cur_node     = '0;
    logic [ID_W-1:0]     rec_base     = '0;
    logic                rec_coll     = 1'b0;
    logic                rec_back     = 1'b0;

    neighbor_t           expected_q[$];
    bit                  stream_bits[$];
    int                  items_sent    = 0;
    int                  error_count   = 0;
    bit                  calm          = 1'b0;
    int                  hold_requests = 0;
    int                  hold_taken    = 0;
    int                  hold_left     = 0;

    delta_adjacency_list_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .stream_byte (stream_byte),
        .start_bit   (start_bit),
        .group_base  (group_base),
        .collapsed   (collapsed),
        .backward    (backward),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .node_id     (node_id),
        .empty_list  (empty_list),
        .last        (last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] field_mask(input int w);
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic int unsigned cfg_width(input logic dir, input logic coll, input logic kind);
        logic [CFG_W-1:0] r;
        r = width_reg[{dir, coll, kind}];
        if (r == 0)
            return 1;
        if (r > MAX_FIELD)
            return MAX_FIELD;
        return 32'(r);
    endfunction

    function automatic void open_field(input phase_t ph, input int unsigned w);
        dec_phase  = ph;
        field_bits = '0;
        bits_left  = w;
    endfunction

    function automatic void expect_result(input logic [ID_W-1:0] node, input logic empty,
                                          input logic fin);
        neighbor_t r;
        r.node_id    = node;
        r.empty_list = empty;
        r.is_last    = fin;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void emit_entry();
        entries_left = entries_left - 1;
        expect_result(cur_node, 1'b0, entries_left == 0);
        if (entries_left == 0)
            dec_phase = PH_IDLE;
        else
            open_field(PH_DELTA, cfg_width(rec_back, rec_coll, KIND_DELTA));
    endfunction

    function automatic void decode_byte(input logic start, input logic [BYTE_W-1:0] b,
                                        input logic [POS_W-1:0] sb, input logic [ID_W-1:0] base,
                                        input logic coll, input logic back);
        int          pos;
        logic [63:0] v;
        logic [63:0] dw;
        pos = BYTE_W - 1;
        if (start)
        begin
            rec_base     = base;
            rec_coll     = coll;
            rec_back     = back;
            cur_node     = '0;
            entries_left = '0;
            skip_left    = '0;
            open_field(back ? PH_FWD_DEG : PH_DEG, cfg_width(DIR_FWD, coll, KIND_DEGREE));
            pos = BYTE_W - 1 - int'(sb);
        end
        while (pos >= 0 && dec_phase != PH_IDLE)
        begin
            if (dec_phase == PH_SKIP)
            begin
                skip_left = skip_left - 1;
                if (skip_left == 0)
                    open_field(PH_DEG, cfg_width(DIR_BACK, rec_coll, KIND_DEGREE));
            end
            else
            begin
                field_bits = {field_bits[62:0], b[pos]};
                if (bits_left > 0)
                    bits_left = bits_left - 1;
                if (bits_left == 0)
                begin
                    v = field_bits;
                    case (dec_phase)
                        PH_FWD_DEG:
                        begin
                            dw = cfg_width(DIR_FWD, rec_coll, KIND_DELTA);
                            if (v == 0)
                                open_field(PH_DEG, cfg_width(DIR_BACK, rec_coll, KIND_DEGREE));
                            else
                            begin
                                dec_phase = PH_SKIP;
                                skip_left = dw + 64'd1 + (v - 64'd1) * dw;
                            end
                        end
                        PH_DEG:
                        begin
                            if (v == 0)
                            begin
                                expect_result('0, 1'b1, 1'b1);
                                dec_phase = PH_IDLE;
                            end
                            else
                            begin
                                entries_left = v;
                                open_field(PH_FIRST, cfg_width(rec_back, rec_coll, KIND_DELTA) + 1);
                            end
                        end
                        PH_FIRST:
                        begin
                            cur_node = v[0] ? rec_base - v[32:1] : rec_base + v[32:1];
                            emit_entry();
                        end
                        PH_DELTA:
                        begin
                            cur_node = cur_node + v[31:0];
                            emit_entry();
                        end
                        default: dec_phase = PH_IDLE;
                    endcase
                end
            end
            pos--;
        end
    endfunction

    function automatic void push_bits(input logic [63:0] v, input int w);
        for (int i = w - 1; i >= 0; i--)
            stream_bits.insert(stream_bits.size(), v[i]);
    endfunction

    task automatic send_byte(input logic start, input logic [BYTE_W-1:0] b,
                             input logic [POS_W-1:0] sb, input logic [ID_W-1:0] base,
                             input logic coll, input logic back);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 20)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= start;
        stream_byte <= b;
        start_bit   <= sb;
        group_base  <= base;
        collapsed   <= coll;
        backward    <= back;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (start || dec_phase != PH_IDLE)
            items_sent++;
        decode_byte(start, b, sb, base, coll, back);
    endtask

    // pack one record behind sb filler bits, pad to a byte, drop cut trailing bytes
    task automatic send_record(input logic [POS_W-1:0] sb, input logic [ID_W-1:0] base,
                               input logic coll, input logic back, input logic [63:0] fwd_cnt,
                               input logic [63:0] cnt, input logic [63:0] first_val,
                               input int fill, input int cut);
        int                dgw;
        int                dlw;
        int                nbytes;
        logic [63:0]       skip;
        logic [BYTE_W-1:0] b;
        bit                abandoned;
        stream_bits.delete();
        abandoned = 1'b0;
        push_bits(rand_word(), sb);
        if (back)
        begin
            dgw = cfg_width(DIR_FWD, coll, KIND_DEGREE);
            dlw = cfg_width(DIR_FWD, coll, KIND_DELTA);
            if (fwd_cnt > field_mask(dgw))
                fwd_cnt = field_mask(dgw);
            push_bits(fwd_cnt, dgw);
            skip = (fwd_cnt == 0) ? 64'd0 : dlw + 64'd1 + (fwd_cnt - 64'd1) * dlw;
            abandoned = skip > SKIP_LIMIT;
            repeat (abandoned ? 24 : skip)
                stream_bits.insert(stream_bits.size(), 1'($urandom_range(1)));
        end
        if (!abandoned)
        begin
            dgw = cfg_width(back, coll, KIND_DEGREE);
            dlw = cfg_width(back, coll, KIND_DELTA);
            if (cnt > field_mask(dgw))
                cnt = field_mask(dgw);
            push_bits(cnt, dgw);
            if (cnt != 0)
            begin
                push_bits(first_val, dlw + 1);
                repeat (cnt - 1)
                    push_bits(fill == FILL_ZERO ? 64'd0 :
                              fill == FILL_ONES ? {64{1'b1}} : rand_word(), dlw);
            end
        end
        while (stream_bits.size() % BYTE_W != 0)
            stream_bits.insert(stream_bits.size(), 1'($urandom_range(1)));
        nbytes = stream_bits.size() / BYTE_W;
        if (cut > 0)
            nbytes = (nbytes > cut) ? nbytes - cut : 1;
        for (int i = 0; i < nbytes; i++)
        begin
            for (int j = 0; j < BYTE_W; j++)
                b[BYTE_W - 1 - j] = stream_bits[BYTE_W * i + j];
            if (i == 0)
                send_byte(1'b1, b, sb, base, coll, back);
            else
                send_byte(1'b0, b, POS_W'($urandom), $urandom, 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_records(input int budget);
        int          stop_at;
        int          pick;
        logic [63:0] fwd_cnt;
        logic [63:0] cnt;
        int          fill;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            pick    = $urandom_range(99);
            fwd_cnt = ($urandom_range(99) < 4) ? {64{1'b1}} : 64'($urandom_range(3));
            cnt     = ($urandom_range(99) < 10) ? 64'd0 : 64'($urandom_range(1, 8));
            fill    = $urandom_range(9) < 8 ? FILL_RANDOM :
                      int'($urandom_range(FILL_ONES, FILL_ZERO));
            if (pick < 8)
                send_byte(1'($urandom_range(1)), BYTE_W'($urandom), POS_W'($urandom), $urandom,
                          1'($urandom), 1'($urandom));
            else
                send_record(POS_W'($urandom),
                            pick < 16 ? '0 : pick < 24 ? {ID_W{1'b1}} : $urandom,
                            1'($urandom_range(1)), $urandom_range(99) < 35, fwd_cnt, cnt,
                            rand_word(), fill, pick < 18 ? int'($urandom_range(1, 3)) : 0);
        end
    endtask

    // ws holds register 0 in its lowest CFG_W bits
    task automatic load_widths(input logic [CFG_N*CFG_W-1:0] ws);
        for (int i = 0; i < CFG_N; i++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(i * REG_STRIDE);
            pwdata  <= DATA_W'(ws[i*CFG_W +: CFG_W]);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            width_reg[i] = ws[i*CFG_W +: CFG_W];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        // ignored while idle
        send_byte(1'b0, 8'hFF, 3'd0, '0, 1'b0, 1'b0);
        // zero degree
        send_byte(1'b1, 8'h00, 3'd0, {ID_W{1'b1}}, 1'b0, 1'b0);
        // cut short, then dropped by the next start
        send_record(3'd0, {ID_W{1'b1}}, 1'b1, 1'b0, 64'd0, 64'd3, rand_word(), FILL_RANDOM, 2);
        send_record(3'd7, '0, 1'b0, 1'b0, 64'd0, 64'd1, 64'd1, FILL_RANDOM, 0);
        send_record(3'd3, {ID_W{1'b1}}, 1'b0, 1'b0, 64'd0, 64'd3, 64'h1FE, FILL_ONES, 0);
        send_record(3'd5, '0, 1'b1, 1'b0, 64'd0, 64'd2, 64'h1FF, FILL_ZERO, 0);
        send_record(3'd1, 32'h8000_0000, 1'b1, 1'b1, 64'd1, 64'd2, rand_word(), FILL_RANDOM, 0);
        send_record(3'd6, $urandom, 1'b0, 1'b1, 64'd0, 64'd0, 64'd0, FILL_RANDOM, 0);
        drain_results();
    endtask

    task automatic test_narrow_widths();
        load_widths({CFG_N{6'd1}});
        run_records(60);
        drain_results();
    endtask

    task automatic test_wide_widths();
        calm = 1'b1;
        load_widths({CFG_N{6'd32}});
        run_records(60);
        drain_results();
        calm = 1'b0;
    endtask

    task automatic test_width_clamp();
        load_widths({6'd0, 6'd63, 6'd34, 6'd0, 6'd40, 6'd33, 6'd0, 6'd63});
        run_records(60);
        drain_results();
    endtask

    task automatic test_random_widths();
        logic [CFG_N*CFG_W-1:0] ws;
        int                     r;
        repeat (5)
        begin
            for (int i = 0; i < CFG_N; i++)
            begin
                r = $urandom_range(99);
                ws[i*CFG_W +: CFG_W] = r < 75 ? CFG_W'($urandom_range(1, 6)) :
                                       r < 95 ? CFG_W'($urandom_range(7, 32)) :
                                       ($urandom_range(1) ? CFG_W'(0) :
                                                            CFG_W'($urandom_range(33, 63)));
            end
            load_widths(ws);
            run_records(40);
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        load_widths({4{6'd1, 6'd3}});
        hold_requests++;
        run_records(60);
        drain_results();
    endtask

    always @(posedge clk)
    begin : result_monitor
        neighbor_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected transfer: expected none, actual node_id %h empty_list %b last %b",
                         $time, node_id, empty_list, last);
            end
            else
            begin
                want = expected_q.pop_front();
                if (node_id !== want.node_id)
                begin
                    error_count++;
                    $display("%0t node_id: expected %h, actual %h", $time, want.node_id, node_id);
                end
                if (empty_list !== want.empty_list)
                begin
                    error_count++;
                    $display("%0t empty_list: expected %b, actual %b",
                             $time, want.empty_list, empty_list);
                end
                if (last !== want.is_last)
                begin
                    error_count++;
                    $display("%0t last: expected %b, actual %b", $time, want.is_last, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin : stall_driver
        if (hold_taken != hold_requests)
        begin
            hold_taken = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 20);
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("delta_adjacency_list_decoder_unit regression: fail");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < CFG_N; i++)
            width_reg[i] = CFG_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_narrow_widths();
        test_wide_widths();
        test_width_clamp();
        test_random_widths();
        test_backpressure();
        if (error_count == 0)
            $display("delta_adjacency_list_decoder_unit regression: pass");
        else
            $display("delta_adjacency_list_decoder_unit regression: fail");
        $finish;
    end

endmodule
